### src/aging_priority_arbiter_assert.svh
// Assertion macros shared by the aging priority arbiter.
`ifndef AGING_PRIORITY_ARBITER_ASSERT_SVH
`define AGING_PRIORITY_ARBITER_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define APA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define APA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/apa_pkg.sv
// Shared types and constants of the aging priority arbiter.
package apa_pkg;

  localparam int unsigned ID_W       = 8;
  localparam int unsigned REQ_PRIO_W = 8;

  typedef enum logic {
    OP_ENTER = 1'b0,
    OP_GRANT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    RES_ENTERED = 2'd0,
    RES_FULL    = 2'd1,
    RES_GRANT   = 2'd2
  } res_kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      in_ready;
    logic      load;
    logic      idx_clr;
    logic      step;
    logic      enter_write;
    logic      issue_scan;
    logic      issue_age;
    logic      clear_pick;
    logic      res_set;
    res_kind_e res_kind;
    logic      post;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic in_op;
    logic slot_free;
    logic idx_last;
    logic grantable;
    logic out_free;
  } sts_t;

endpackage

### src/apa_if.sv
// Valid/ready channels carrying the arbiter's input and result items.
interface apa_in_if import apa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [ID_W-1:0]       requester_id;
  logic [REQ_PRIO_W-1:0] priority_req;

  modport source (output valid, op, requester_id, priority_req, input ready);
  modport sink (input valid, op, requester_id, priority_req, output ready);
endinterface

interface apa_out_if import apa_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            grant_valid;
  logic [ID_W-1:0] granted_id;
  logic            rejected_full;

  modport source (output valid, grant_valid, granted_id, rejected_full, input ready);
  modport sink (input valid, grant_valid, granted_id, rejected_full, output ready);
endinterface

### src/aging_priority_arbiter.sv
// Top level of the aging priority arbiter: controller, datapath and checks.
//
// Holds SLOTS waiting requesters, each with an id and a priority, in a small
// memory walked one slot per cycle through a single read port, and handles one
// item at a time. An enter item takes its requester to the lowest free slot,
// or is rejected as full when no slot is free. A grant item scans every slot
// for the highest non-zero priority (lowest slot wins a tie), frees the winner,
// then walks the table again to age every other waiting slot by one, saturating
// at the top priority; when nothing can be granted, no ageing walk follows. A
// finished result sits in an output register, so a new item can be accepted
// while the sink has not yet taken it; if that register still holds an untaken
// result when the next one is ready, the item waits in its done state until the
// sink takes the older result.
`include "aging_priority_arbiter_assert.svh"

module aging_priority_arbiter import apa_pkg::*; #(
  parameter int unsigned SLOTS         = 32,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  apa_in_if.sink    in_i,
  apa_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  apa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Slot table and result path
  apa_dp #(
    .SLOTS         (SLOTS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  // Checks
  `APA_ASSERT_SAME(a_enter_free, cmd.enter_write, sts.slot_free, "enter wrote an occupied slot")
  `APA_ASSERT_SAME(a_post_free, cmd.post, sts.out_free, "result overwrote an untaken item")
  `APA_ASSERT_SAME(a_pick_grant, cmd.clear_pick, sts.grantable, "slot freed without a grant")
  `APA_ASSERT_NEXT(a_busy_after, in_i.valid && in_i.ready, !in_i.ready, "item taken while busy")

endmodule

### src/apa_ctrl.sv
// Controller state machine sequencing enter, scan and ageing passes.
module apa_ctrl import apa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE       = 8'b0000_0001,
    ST_ENTER      = 8'b0000_0010,
    ST_SCAN       = 8'b0000_0100,
    ST_SCAN_DRAIN = 8'b0000_1000,
    ST_DECIDE     = 8'b0001_0000,
    ST_AGE        = 8'b0010_0000,
    ST_AGE_DRAIN  = 8'b0100_0000,
    ST_DONE       = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.load    = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d = (sts_i.in_op == OP_ENTER) ? ST_ENTER : ST_SCAN;
        end
      end
      ST_ENTER: begin
        if (sts_i.slot_free) begin
          cmd_o.enter_write = 1'b1;
          cmd_o.res_set     = 1'b1;
          cmd_o.res_kind    = RES_ENTERED;
          state_d = ST_DONE;
        end else if (sts_i.idx_last) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_kind = RES_FULL;
          state_d = ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd_o.issue_scan = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_SCAN_DRAIN;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_SCAN_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.res_set  = 1'b1;
        cmd_o.res_kind = RES_GRANT;
        if (sts_i.grantable) begin
          cmd_o.clear_pick = 1'b1;
          cmd_o.idx_clr    = 1'b1;
          state_d = ST_AGE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_AGE: begin
        cmd_o.issue_age = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_AGE_DRAIN;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_AGE_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.post = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/apa_dp.sv
// Datapath: slot table, slot walker, best-slot search, ageing and result register.
module apa_dp import apa_pkg::*; #(
  parameter int unsigned SLOTS         = 32,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  apa_in_if.sink    in_i,
  apa_out_if.source out_o,
  input  cmd_t      cmd_i,
  output sts_t      sts_o
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CMP_W = (PRIORITY_BITS > REQ_PRIO_W) ? PRIORITY_BITS : REQ_PRIO_W;
  localparam logic [PRIORITY_BITS-1:0] PRIO_MAX = {PRIORITY_BITS{1'b1}};

  logic [SLOTS-1:0]         valid_q;
  logic [IDX_W-1:0]         idx_q;
  logic [ID_W-1:0]          item_id_q;
  logic [PRIORITY_BITS-1:0] item_prio_q;
  logic [PRIORITY_BITS-1:0] prio_sat;
  logic [CMP_W-1:0]         prio_ext;

  logic [PRIORITY_BITS-1:0] prio_mem [SLOTS];
  logic [ID_W-1:0]          req_mem  [SLOTS];

  logic                     rd_act_q;
  logic                     rd_age_q;
  logic                     rd_live_q;
  logic [IDX_W-1:0]         rd_idx_q;
  logic [PRIORITY_BITS-1:0] rd_prio_q;
  logic [ID_W-1:0]          rd_req_q;

  logic [PRIORITY_BITS-1:0] best_q;
  logic [IDX_W-1:0]         pick_q;
  logic [ID_W-1:0]          best_id_q;
  logic                     grantable;
  logic                     age_write;

  logic                     res_grant_q;
  logic [ID_W-1:0]          res_id_q;
  logic                     res_full_q;
  logic                     out_valid_q;
  logic                     out_grant_q;
  logic [ID_W-1:0]          out_id_q;
  logic                     out_full_q;

  // Saturate the entering priority to the table's priority width
  assign prio_ext = CMP_W'(in_i.priority_req);
  assign prio_sat = (prio_ext > CMP_W'(PRIO_MAX)) ? PRIO_MAX : PRIORITY_BITS'(prio_ext);

  assign grantable = (best_q != '0);
  assign age_write = rd_act_q && rd_age_q && rd_live_q && (rd_prio_q != PRIO_MAX);

  // Status towards the controller
  assign in_i.ready      = cmd_i.in_ready;
  assign sts_o.in_valid  = in_i.valid;
  assign sts_o.in_op     = in_i.op;
  assign sts_o.slot_free = !valid_q[idx_q];
  assign sts_o.idx_last  = (idx_q == IDX_W'(SLOTS - 1));
  assign sts_o.grantable = grantable;
  assign sts_o.out_free  = !out_valid_q || out_o.ready;

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_id_q   <= in_i.requester_id;
      item_prio_q <= prio_sat;
    end
  end

  // Walk the slots one per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.enter_write) begin
      valid_q[idx_q] <= 1'b1;
    end else if (cmd_i.clear_pick) begin
      valid_q[pick_q] <= 1'b0;
    end
  end

  // Table memories: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (cmd_i.enter_write) begin
      prio_mem[idx_q] <= item_prio_q;
    end else if (age_write) begin
      prio_mem[rd_idx_q] <= rd_prio_q + 1'b1;
    end
    rd_prio_q <= prio_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.enter_write) begin
      req_mem[idx_q] <= item_id_q;
    end
    rd_req_q <= req_mem[idx_q];
  end

  // Read stage tags, aligned with the registered read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_act_q <= 1'b0;
      rd_age_q <= 1'b0;
    end else begin
      rd_act_q <= cmd_i.issue_scan || cmd_i.issue_age;
      rd_age_q <= cmd_i.issue_age;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= idx_q;
    rd_live_q <= valid_q[idx_q];
  end

  // Track the highest priority seen; strict compare keeps the lowest slot on a tie
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      best_q <= '0;
    end else if (rd_act_q && !rd_age_q && rd_live_q && (rd_prio_q > best_q)) begin
      best_q    <= rd_prio_q;
      pick_q    <= rd_idx_q;
      best_id_q <= rd_req_q;
    end
  end

  // Pending result of the current item
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      unique case (cmd_i.res_kind)
        RES_ENTERED: begin
          res_grant_q <= 1'b0;
          res_id_q    <= '0;
          res_full_q  <= 1'b0;
        end
        RES_FULL: begin
          res_grant_q <= 1'b0;
          res_id_q    <= '0;
          res_full_q  <= 1'b1;
        end
        RES_GRANT: begin
          res_grant_q <= grantable;
          res_id_q    <= grantable ? best_id_q : '0;
          res_full_q  <= 1'b0;
        end
        default: begin
          res_grant_q <= 1'b0;
          res_id_q    <= '0;
          res_full_q  <= 1'b0;
        end
      endcase
    end
  end

  // Output register: hold the item until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.post) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.post) begin
      out_grant_q <= res_grant_q;
      out_id_q    <= res_id_q;
      out_full_q  <= res_full_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.grant_valid   = out_grant_q;
  assign out_o.granted_id    = out_id_q;
  assign out_o.rejected_full = out_full_q;

endmodule

### verif/tb_aging_priority_arbiter.sv
// Self-checking testbench for the aging priority arbiter.
module tb_aging_priority_arbiter;
  import apa_pkg::*;

  localparam int unsigned SLOTS         = 32;
  localparam int unsigned PRIORITY_BITS = 8;
  localparam int          ITEM_TARGET   = 1450;
  localparam int          QUIET_TAIL    = 150;
  localparam int          DRAIN_CYCLES  = 2 * SLOTS + 16;

  // Mirror of the waiting table; predicts one verdict per accepted item.
  class grant_scoreboard #(int SLOT_COUNT = 32, int LEVEL_BITS = 8);
    localparam int LEVEL_TOP = (1 << LEVEL_BITS) - 1;

    typedef struct packed {
      logic            grant_valid;
      logic [ID_W-1:0] granted_id;
      logic            rejected_full;
    } verdict_t;

    bit              occupied[SLOT_COUNT];
    bit [ID_W-1:0]   owner[SLOT_COUNT];
    int              level[SLOT_COUNT];
    verdict_t        awaited[$];
    int              errors;
    int              checked;

    function new();
      foreach (occupied[i]) begin
        occupied[i] = 1'b0;
        owner[i]    = '0;
        level[i]    = 0;
      end
      errors  = 0;
      checked = 0;
    endfunction

    // Apply one accepted item to the mirror and queue its verdict.
    function void note_item(op_e op, bit [ID_W-1:0] id, bit [REQ_PRIO_W-1:0] req);
      verdict_t v;
      int       best;
      int       pick;
      bit       placed;
      v      = '0;
      best   = 0;
      pick   = 0;
      placed = 1'b0;
      if (op == OP_ENTER) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!placed && !occupied[i]) begin
            occupied[i] = 1'b1;
            owner[i]    = id;
            level[i]    = (int'(req) > LEVEL_TOP) ? LEVEL_TOP : int'(req);
            placed      = 1'b1;
          end
        end
        v.rejected_full = !placed;
      end else begin
        // Highest non-zero level wins; strict compare keeps the lowest slot on a tie.
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (occupied[i] && level[i] > best) begin
            best = level[i];
            pick = i;
          end
        end
        if (best > 0) begin
          v.grant_valid = 1'b1;
          v.granted_id  = owner[pick];
          occupied[pick] = 1'b0;
          level[pick]    = 0;
          // Age every other waiting slot, saturating at the top level.
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (occupied[i] && level[i] < LEVEL_TOP) level[i]++;
          end
        end
      end
      awaited.push_back(v);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    // Compare one delivered result with the oldest queued verdict.
    task check_result(logic gv, logic [ID_W-1:0] gid, logic rf);
      verdict_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result gv=%b id=%h full=%b", gv, gid, rf));
      end else begin
        want = awaited.pop_front();
        checked++;
        if (gv !== want.grant_valid)
          report($sformatf("result %0d grant_valid %b, want %b", checked, gv,
                           want.grant_valid));
        if (gid !== want.granted_id)
          report($sformatf("result %0d granted_id %h, want %h", checked, gid,
                           want.granted_id));
        if (rf !== want.rejected_full)
          report($sformatf("result %0d rejected_full %b, want %b", checked, rf,
                           want.rejected_full));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   idle_on;
  int   ready_hold;
  int   sent_count;

  apa_in_if  in_if ();
  apa_out_if out_if ();

  grant_scoreboard #(.SLOT_COUNT(SLOTS), .LEVEL_BITS(PRIORITY_BITS)) sb;

  aging_priority_arbiter #(
    .SLOTS        (SLOTS),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Note every accepted input item.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid === 1'b1 && in_if.ready === 1'b1)
      sb.note_item(op_e'(in_if.op), in_if.requester_id, in_if.priority_req);
  end

  // Check every accepted result item.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_result(out_if.grant_valid, out_if.granted_id, out_if.rejected_full);
  end

  // Result sink: stall in short random bursts while idling is enabled.
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      out_if.ready = 1'b0;
      ready_hold--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_if.ready = 1'b0;
      ready_hold   = $urandom_range(0, 3);
    end else begin
      out_if.ready = 1'b1;
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("tb_aging_priority_arbiter: done, errors");
    $finish;
  end

  // Present one item at a falling edge and hold it until accepted.
  task send_item(op_e op, bit [ID_W-1:0] id, bit [REQ_PRIO_W-1:0] req);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_if.valid        = 1'b1;
    in_if.op           = op;
    in_if.requester_id = id;
    in_if.priority_req = req;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sent_count++;
  endtask

  // Bias levels towards zero, ties and the top of the range.
  function automatic bit [REQ_PRIO_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return '1;
      3, 4, 5: return REQ_PRIO_W'($urandom_range(1, 4));
      6:       return REQ_PRIO_W'($urandom_range(250, 255));
      default: return REQ_PRIO_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int  run;
    int  enter_pct;
    op_e op;
    sb                  = new();
    rst_ni              = 1'b0;
    idle_on             = 1'b0;
    ready_hold          = 0;
    sent_count          = 0;
    in_if.valid         = 1'b0;
    in_if.op            = OP_ENTER;
    in_if.requester_id  = '0;
    in_if.priority_req  = '0;
    out_if.ready        = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty grant, zero level, top-level tie, saturated aging.
    send_item(OP_GRANT, 8'h00, 8'h00);
    send_item(OP_ENTER, 8'h00, 8'h00);
    send_item(OP_GRANT, 8'h00, 8'h00);
    send_item(OP_ENTER, 8'hFF, 8'hFF);
    send_item(OP_ENTER, 8'hA5, 8'hFF);
    send_item(OP_ENTER, 8'h5A, 8'h01);
    send_item(OP_GRANT, 8'hFF, 8'hFF);
    send_item(OP_GRANT, 8'h00, 8'h00);
    send_item(OP_GRANT, 8'h00, 8'h00);
    send_item(OP_GRANT, 8'h00, 8'h00);
    send_item(OP_GRANT, 8'h00, 8'h00);
    // Mid-range bit patterns on both fields, then ties among equal levels.
    send_item(OP_ENTER, 8'h80, 8'h7F);
    send_item(OP_ENTER, 8'h7F, 8'h80);
    send_item(OP_ENTER, 8'h01, 8'h80);
    send_item(OP_GRANT, 8'h00, 8'h00);
    send_item(OP_GRANT, 8'h00, 8'h00);
    send_item(OP_GRANT, 8'h00, 8'h00);
    send_item(OP_GRANT, 8'h00, 8'h00);

    // Random: fill, drain and mixed runs, with idling switched per run.
    while (sent_count < ITEM_TARGET) begin
      idle_on = (sent_count < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0: begin
          run       = $urandom_range(20, 45);
          enter_pct = 88;
        end
        1: begin
          run       = $urandom_range(10, 40);
          enter_pct = 15;
        end
        default: begin
          run       = $urandom_range(10, 30);
          enter_pct = 50;
        end
      endcase
      repeat (run) begin
        op = ($urandom_range(0, 99) < enter_pct) ? OP_ENTER : OP_GRANT;
        send_item(op, ID_W'($urandom_range(0, 255)), pick_level());
      end
    end

    @(negedge clk_i);
    in_if.valid = 1'b0;
    idle_on     = 1'b0;

    // Drain outstanding results, then let the block settle.
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("tb_aging_priority_arbiter: done, clean");
    end else begin
      $display("tb_aging_priority_arbiter: done, errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/apa_pkg.sv
src/apa_if.sv
src/apa_ctrl.sv
src/apa_dp.sv
src/aging_priority_arbiter.sv
verif/tb_aging_priority_arbiter.sv
